// ===== sv/ptrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared types and constants for the prime test with running mean.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  localparam int unsigned CAND_PORT_W = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned MEAN_W      = 24;
  localparam int unsigned MQ_W        = SUM_W + FRAC_BITS;
  localparam int unsigned MSTEP_W     = $clog2(MQ_W);
  localparam int unsigned FIRST_PRIME = 2;

  // Input request
  typedef struct packed {
    logic [CAND_PORT_W-1:0] candidate;
    logic                   last_of_range;
  } in_t;

  // Result request
  typedef struct packed {
    logic              is_prime;
    logic [COUNT_W-1:0] prime_count;
    logic [SUM_W-1:0]   prime_sum;
    logic [MEAN_W-1:0]  mean_fixed;
    logic              none_found;
    logic              range_end;
  } out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACC,
    ST_MEAN_CHK,
    ST_MEAN,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic acc_update;
    logic mean_start;
    logic mean_step;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic check_done;
    logic div_last;
    logic mean_needed;
    logic mean_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/prime_test_with_running_mean.sv =====
`timescale 1ns / 1ps
// Flow: load, then per divisor tried a check and a bit-serial remainder over W
//   bits, W = min(VALUE_BITS, 16); divisors tried: up to floor(sqrt(n)) - 1. Then
//   accumulate and, on a range end with primes, divide for the mean; then emit.
// One request at a time: input stalls until the result register takes the result.
// Reset: controller returns to idle, result valid drops, count and sum clear to zero.
// ----------------------------------------------------------------------------
// prime_test_with_running_mean
// Trial-division primality test with running prime count, sum and mean.
// ----------------------------------------------------------------------------
module prime_test_with_running_mean #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ptrm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ptrm_pkg::out_t out_data
);

  ptrm_pkg::cmd_t cmd;
  ptrm_pkg::sts_t sts;

  // Sequence the work
  ptrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Do the arithmetic and hold the result
  ptrm_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/ptrm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_ctrl
// Sequencer for trial division, accumulation, mean division and result hand-off.
// ----------------------------------------------------------------------------
module ptrm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ptrm_pkg::sts_t  sts,
  output ptrm_pkg::cmd_t  cmd
);

  ptrm_pkg::state_t state_r;
  ptrm_pkg::state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptrm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ptrm_pkg::ST_CHECK;
      end
      ptrm_pkg::ST_CHECK: begin
        if (sts.check_done) state_nxt = ptrm_pkg::ST_ACC;
        else                state_nxt = ptrm_pkg::ST_DIV;
      end
      ptrm_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = ptrm_pkg::ST_CHECK;
      end
      ptrm_pkg::ST_ACC: begin
        state_nxt = ptrm_pkg::ST_MEAN_CHK;
      end
      ptrm_pkg::ST_MEAN_CHK: begin
        if (sts.mean_needed) state_nxt = ptrm_pkg::ST_MEAN;
        else                 state_nxt = ptrm_pkg::ST_EMIT;
      end
      ptrm_pkg::ST_MEAN: begin
        if (sts.mean_last) state_nxt = ptrm_pkg::ST_EMIT;
      end
      ptrm_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = ptrm_pkg::ST_IDLE;
      end
      default: state_nxt = ptrm_pkg::ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ptrm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ptrm_pkg::ST_CHECK: begin
        cmd.div_start = !sts.check_done;
      end
      ptrm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ptrm_pkg::ST_ACC: begin
        cmd.acc_update = 1'b1;
      end
      ptrm_pkg::ST_MEAN_CHK: begin
        cmd.mean_start = sts.mean_needed;
      end
      ptrm_pkg::ST_MEAN: begin
        cmd.mean_step = 1'b1;
      end
      ptrm_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/ptrm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_dp
// Datapath: bit-serial trial divider, accumulators, mean divider, result register.
// ----------------------------------------------------------------------------
module ptrm_dp #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ptrm_pkg::in_t   in_data,
  input  ptrm_pkg::cmd_t  cmd,
  output ptrm_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_stall,
  output ptrm_pkg::out_t  out_data
);

  localparam int unsigned CAND_W = (VALUE_BITS < ptrm_pkg::CAND_PORT_W) ?
                                   VALUE_BITS : ptrm_pkg::CAND_PORT_W;
  localparam int unsigned DW     = CAND_W / 2 + 2;
  localparam int unsigned SQW    = CAND_W + 2;
  localparam int unsigned BW     = $clog2(CAND_W);
  localparam int unsigned COUNT_W = ptrm_pkg::COUNT_W;
  localparam int unsigned SUM_W   = ptrm_pkg::SUM_W;
  localparam int unsigned MQ_W    = ptrm_pkg::MQ_W;
  localparam int unsigned MEAN_W  = ptrm_pkg::MEAN_W;
  localparam int unsigned MSTEP_W = ptrm_pkg::MSTEP_W;

  logic [CAND_W-1:0]  n_r;
  logic               last_r;
  logic               prime_r;
  logic [DW-1:0]      d_r;
  logic [SQW-1:0]     sq_r;
  logic [DW-1:0]      rem_r;
  logic [BW-1:0]      bit_r;
  logic [COUNT_W-1:0] count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [MQ_W-1:0]    mq_r;
  logic [COUNT_W-1:0] mrem_r;
  logic [MSTEP_W-1:0] mstep_r;
  logic               out_valid_r;
  ptrm_pkg::out_t     out_r;

  logic [CAND_W-1:0]  cand;
  logic [DW:0]        shift_w;
  logic               ge;
  logic [DW-1:0]      rem_step;
  logic [SUM_W:0]     sum_ext;
  logic [COUNT_W:0]   mshift;
  logic               mge;
  logic [COUNT_W-1:0] mrem_step;
  logic [MEAN_W-1:0]  mean_sat;

  assign cand = in_data.candidate[CAND_W-1:0];

  // One restoring step of n mod d, most significant bit first
  assign shift_w  = {rem_r, n_r[bit_r]};
  assign ge       = shift_w >= {1'b0, d_r};
  assign rem_step = ge ? DW'(shift_w - {1'b0, d_r}) : shift_w[DW-1:0];

  // One restoring step of (sum << 8) / count
  assign mshift    = {mrem_r, mq_r[MQ_W-1]};
  assign mge       = mshift >= {1'b0, count_r};
  assign mrem_step = mge ? COUNT_W'(mshift - {1'b0, count_r}) : mshift[COUNT_W-1:0];
  assign mean_sat  = (|mq_r[MQ_W-1:MEAN_W]) ? '1 : mq_r[MEAN_W-1:0];

  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(n_r);

  // Status to the controller
  assign sts.check_done  = !prime_r || (sq_r > SQW'(n_r));
  assign sts.div_last    = (bit_r == '0);
  assign sts.mean_needed = last_r && (count_r != '0);
  assign sts.mean_last   = (mstep_r == MSTEP_W'(MQ_W - 1));
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Trial division: load candidate, step remainder, advance divisor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r     <= cand;
      last_r  <= in_data.last_of_range;
      prime_r <= cand >= CAND_W'(ptrm_pkg::FIRST_PRIME);
      d_r     <= DW'(ptrm_pkg::FIRST_PRIME);
      sq_r    <= SQW'(ptrm_pkg::FIRST_PRIME * ptrm_pkg::FIRST_PRIME);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      bit_r <= BW'(CAND_W - 1);
    end
    if (cmd.div_step) begin
      rem_r <= rem_step;
      bit_r <= bit_r - 1'b1;
      if (bit_r == '0) begin
        if (rem_step == '0) prime_r <= 1'b0;
        d_r  <= d_r + 1'b1;
        sq_r <= sq_r + SQW'({d_r, 1'b1});
      end
    end
  end

  // Accumulate primes of the range; clear after the range end is handed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      if (cmd.acc_update && prime_r) begin
        if (count_r != '1) count_r <= count_r + 1'b1;
        sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
      if (cmd.emit && last_r) begin
        count_r <= '0;
        sum_r   <= '0;
      end
    end
  end

  // Mean divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.mean_start) begin
      mq_r    <= {sum_r, {ptrm_pkg::FRAC_BITS{1'b0}}};
      mrem_r  <= '0;
      mstep_r <= '0;
    end else if (cmd.mean_step) begin
      mq_r    <= {mq_r[MQ_W-2:0], mge};
      mrem_r  <= mrem_step;
      mstep_r <= mstep_r + 1'b1;
    end
  end

  // Result register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.is_prime    <= prime_r;
      out_r.prime_count <= count_r;
      out_r.prime_sum   <= sum_r;
      out_r.mean_fixed  <= sts.mean_needed ? mean_sat : '0;
      out_r.none_found  <= last_r && (count_r == '0);
      out_r.range_end   <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
